// ===== rtl/websocket_frame_deframer_top_macros.svh =====
// assertion macros shared by the websocket deframer rtl
// no dependencies; taken in by the files that carry assertions
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WSFD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("wsfd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define WSFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("wsfd assertion failed");

`endif

// ===== rtl/wsfd_pkg.sv =====
// types and constants for the websocket frame deframer
// no dependencies
package wsfd_pkg;

  // header field masks and extended length markers
  localparam logic [7:0] FinMask    = 8'h80;
  localparam logic [7:0] OpMask     = 8'h0F;
  localparam logic [7:0] Len7Mask   = 8'h7F;
  localparam logic [6:0] Len7Ext16  = 7'd126;
  localparam logic [6:0] Len7Ext64  = 7'd127;
  localparam int unsigned LenW      = 64;

  // opcodes with a dispatch of their own
  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose  = 4'h8;
  localparam logic [3:0] OpPing   = 4'h9;
  localparam logic [3:0] OpPong   = 4'hA;

  typedef enum logic [2:0] {
    ActText     = 3'd0,
    ActBinary   = 3'd1,
    ActClose    = 3'd2,
    ActSendPong = 3'd3,
    ActPongSeen = 3'd4,
    ActIgnore   = 3'd5
  } action_e;

  // one result item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] frame_code;
    logic       final_flag;
    logic       end_of_frame;
    action_e    action;
  } res_t;

  // dispatch action for an opcode
  function automatic action_e action_of(logic [3:0] op);
    action_e a;
    unique case (op)
      OpText:   a = ActText;
      OpBinary: a = ActBinary;
      OpClose:  a = ActClose;
      OpPing:   a = ActSendPong;
      OpPong:   a = ActPongSeen;
      default:  a = ActIgnore;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/wsfd_if.sv =====
// handshake channels of the websocket frame deframer
// depends on nothing; one interface per channel direction

// stream byte channel
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// result item channel
interface wsfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_data;
  logic [3:0] frame_code;
  logic       final_flag;
  logic       end_of_frame;
  logic [2:0] action;

  modport source (output valid, output data_byte, output has_data, output frame_code,
                  output final_flag, output end_of_frame, output action, input ready);
  modport sink (input valid, input data_byte, input has_data, input frame_code,
                input final_flag, input end_of_frame, input action, output ready);
endinterface

// ===== rtl/wsfd_parser.sv =====
// header parser and payload unmasker, one stream byte per accepted transfer
// depends on wsfd_pkg and the assertion macro header
`include "websocket_frame_deframer_top_macros.svh"

module wsfd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output wsfd_pkg::res_t   res_o
);

  typedef enum logic [2:0] {
    PhHdr1  = 3'd0,
    PhHdr2  = 3'd1,
    PhExt16 = 3'd2,
    PhExt64 = 3'd3,
    PhKey   = 3'd4,
    PhData  = 3'd5
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [3:0]                  op_q, op_d;
  logic                        fin_q, fin_d;
  logic                        masked_q, masked_d;
  logic [wsfd_pkg::LenW-1:0]   len_q, len_d;
  logic [2:0]                  cnt_q, cnt_d;
  logic [3:0][7:0]             key_q, key_d;
  logic [1:0]                  kidx_q, kidx_d;

  logic                        len_fin, key_fin, hdr_fin;
  logic                        res_v;
  logic [7:0]                  res_data;
  logic                        res_has, res_eof;
  logic [6:0]                  len7;

  assign len7 = 7'(byte_i & wsfd_pkg::Len7Mask);

  // next state for one byte
  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    fin_d    = fin_q;
    masked_d = masked_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    kidx_d   = kidx_q;
    len_fin  = 1'b0;
    key_fin  = 1'b0;
    hdr_fin  = 1'b0;
    res_v    = 1'b0;
    res_data = 8'd0;
    res_has  = 1'b0;
    res_eof  = 1'b0;

    unique case (phase_q)
      PhHdr2: begin
        masked_d = |(byte_i & wsfd_pkg::FinMask);
        cnt_d    = 3'd0;
        if (len7 == wsfd_pkg::Len7Ext16) begin
          len_d   = '0;
          phase_d = PhExt16;
        end else if (len7 == wsfd_pkg::Len7Ext64) begin
          len_d   = '0;
          phase_d = PhExt64;
        end else begin
          len_d   = wsfd_pkg::LenW'(len7);
          len_fin = 1'b1;
        end
      end
      PhExt16, PhExt64: begin
        len_d = {len_q[wsfd_pkg::LenW-9:0], byte_i};
        if ((phase_q == PhExt16 && cnt_q == 3'd1) || (phase_q == PhExt64 && cnt_q == 3'd7)) begin
          len_fin = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PhKey: begin
        key_d[cnt_q[1:0]] = byte_i;
        if (cnt_q[1:0] == 2'd3) begin
          key_fin = 1'b1;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PhData: begin
        // remaining count runs down; last byte when one is left
        res_v    = 1'b1;
        res_has  = 1'b1;
        res_data = masked_q ? (byte_i ^ key_q[kidx_q]) : byte_i;
        res_eof  = (len_q == wsfd_pkg::LenW'(1));
        len_d    = len_q - wsfd_pkg::LenW'(1);
        kidx_d   = kidx_q + 2'd1;
        if (res_eof) begin
          phase_d = PhHdr1;
        end
      end
      default: begin
        // first header byte, also taken for an unused phase code
        fin_d   = |(byte_i & wsfd_pkg::FinMask);
        op_d    = 4'(byte_i & wsfd_pkg::OpMask);
        phase_d = PhHdr2;
      end
    endcase

    // length known: collect the key or close the header
    if (len_fin) begin
      cnt_d = 3'd0;
      if (masked_d) begin
        phase_d = PhKey;
      end else begin
        hdr_fin = 1'b1;
      end
    end
    if (key_fin) begin
      hdr_fin = 1'b1;
    end

    // header done: empty frame gives one data-less item
    if (hdr_fin) begin
      kidx_d = 2'd0;
      if (len_d == '0) begin
        phase_d = PhHdr1;
        res_v   = 1'b1;
        res_eof = 1'b1;
      end else begin
        phase_d = PhData;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr1;
      op_q     <= 4'd0;
      fin_q    <= 1'b0;
      masked_q <= 1'b0;
      len_q    <= '0;
      cnt_q    <= 3'd0;
      key_q    <= '0;
      kidx_q   <= 2'd0;
    end else if (acc_i) begin
      phase_q  <= phase_d;
      op_q     <= op_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      key_q    <= key_d;
      kidx_q   <= kidx_d;
    end
  end

  // result item, tagged with the current frame
  assign res_valid_o        = acc_i & res_v;
  assign res_o.data_byte    = res_data;
  assign res_o.has_data     = res_has;
  assign res_o.frame_code   = op_q;
  assign res_o.final_flag   = fin_q;
  assign res_o.end_of_frame = res_eof;
  assign res_o.action       = wsfd_pkg::action_of(op_q);

  // checks
  `WSFD_ASSERT_IMPL(a_empty_is_eof, clk_i, rst_ni, res_valid_o && !res_o.has_data, res_o.end_of_frame)
  `WSFD_ASSERT_IMPL(a_data_len_nonzero, clk_i, rst_ni, phase_q == PhData, len_q != '0)
  `WSFD_ASSERT_NEXT(a_eof_to_hdr1, clk_i, rst_ni, res_valid_o && res_o.end_of_frame, phase_q == PhHdr1)

endmodule

// ===== rtl/wsfd_out_stage.sv =====
// result register between the parser and the output channel
// depends on wsfd_pkg and the assertion macro header
`include "websocket_frame_deframer_top_macros.svh"

module wsfd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  wsfd_pkg::res_t   res_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output wsfd_pkg::res_t   res_o
);

  logic            valid_q, valid_d;
  wsfd_pkg::res_t  res_q;
  logic            acc;

  // a new byte is taken when the register is empty or drains this cycle
  assign in_ready_o = ~valid_q | out_ready_i;
  assign acc        = in_ready_o;

  always_comb begin
    valid_d = valid_q & ~out_ready_i;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, loaded only with a fresh item
  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // checks
  `WSFD_ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o, out_valid_o)
  `WSFD_ASSERT_NEXT(a_item_lands, clk_i, rst_ni, res_valid_i, out_valid_o)
  `WSFD_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, res_valid_i, acc)

endmodule

// ===== rtl/websocket_frame_deframer_top.sv =====
// websocket frame deframer, receive side: parser plus result register
// depends on wsfd_pkg, wsfd_if, wsfd_parser, wsfd_out_stage
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    rx_byte[7:0]
//   res_o    out  valid/ready    data_byte, has_data, frame_code, final_flag,
//                                end_of_frame, action
//
// one byte accepted per cycle while in_i.ready is high; a result appears in the cycle after its byte
// header bytes give no item; an empty frame gives one item without data
// in_i.ready drops only while a held result is not taken (single result register)
// rst_ni clears the parse state to wait for a first header byte

module websocket_frame_deframer_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  wsfd_in_if.sink      in_i,
  wsfd_out_if.source   res_o
);

  logic            acc;
  logic            ready;
  logic            res_valid;
  wsfd_pkg::res_t  res_comb;
  wsfd_pkg::res_t  res_reg;

  assign in_i.ready = ready;
  assign acc        = in_i.valid & ready;

  wsfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .byte_i      (in_i.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res_comb)
  );

  wsfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_comb),
    .in_ready_o  (ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .res_o       (res_reg)
  );

  // output payload
  assign res_o.data_byte    = res_reg.data_byte;
  assign res_o.has_data     = res_reg.has_data;
  assign res_o.frame_code   = res_reg.frame_code;
  assign res_o.final_flag   = res_reg.final_flag;
  assign res_o.end_of_frame = res_reg.end_of_frame;
  assign res_o.action       = 3'(res_reg.action);

endmodule

// ===== verif/wsfd_checker.sv =====
// result checker for the websocket frame deframer: predicts items from accepted bytes
// depends on wsfd_pkg and the channel interfaces in wsfd_if
`timescale 1ns / 1ps

module wsfd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsfd_in_if          in_mon,
  wsfd_out_if         res_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  typedef enum logic [2:0] {
    PhHdr1, PhHdr2, PhExt16, PhExt64, PhKey, PhData
  } phase_e;

  // predicted parse state
  phase_e      phase     = PhHdr1;
  logic [3:0]  op_q      = '0;
  logic        fin_q     = 1'b0;
  logic        masked_q  = 1'b0;
  logic [63:0] len_q     = '0;
  logic [2:0]  cnt_q     = '0;
  logic [7:0]  key_q [4] = '{default: '0};
  logic [63:0] done_q    = '0;

  wsfd_pkg::res_t frame_items_q [$];

  function automatic wsfd_pkg::action_e dispatch_of(logic [3:0] op);
    case (op)
      wsfd_pkg::OpText:   return wsfd_pkg::ActText;
      wsfd_pkg::OpBinary: return wsfd_pkg::ActBinary;
      wsfd_pkg::OpClose:  return wsfd_pkg::ActClose;
      wsfd_pkg::OpPing:   return wsfd_pkg::ActSendPong;
      wsfd_pkg::OpPong:   return wsfd_pkg::ActPongSeen;
      default:            return wsfd_pkg::ActIgnore;
    endcase
  endfunction

  task automatic push_item(logic [7:0] d, logic has, logic eof);
    wsfd_pkg::res_t r;
    r.data_byte    = d;
    r.has_data     = has;
    r.frame_code   = op_q;
    r.final_flag   = fin_q;
    r.end_of_frame = eof;
    r.action       = dispatch_of(op_q);
    frame_items_q.insert(frame_items_q.size(), r);
  endtask

  // header complete: an empty frame gives a data-less item right away
  task automatic finish_header();
    done_q = '0;
    if (len_q == 64'd0) begin
      phase = PhHdr1;
      push_item(8'h00, 1'b0, 1'b1);
    end else begin
      phase = PhData;
    end
  endtask

  task automatic finish_length();
    cnt_q = '0;
    if (masked_q) begin
      phase = PhKey;
    end else begin
      finish_header();
    end
  endtask

  task automatic deframe_byte(logic [7:0] b);
    logic [7:0] d;
    logic       eof;
    case (phase)
      PhHdr2: begin
        masked_q = b[7];
        cnt_q    = '0;
        if (b[6:0] == wsfd_pkg::Len7Ext16) begin
          len_q = '0;
          phase = PhExt16;
        end else if (b[6:0] == wsfd_pkg::Len7Ext64) begin
          len_q = '0;
          phase = PhExt64;
        end else begin
          len_q = {57'd0, b[6:0]};
          finish_length();
        end
      end
      PhExt16, PhExt64: begin
        len_q = {len_q[55:0], b};
        if ((phase == PhExt16 && cnt_q == 3'd1) || (phase == PhExt64 && cnt_q == 3'd7)) begin
          finish_length();
        end else begin
          cnt_q = cnt_q + 3'd1;
        end
      end
      PhKey: begin
        key_q[cnt_q[1:0]] = b;
        if (cnt_q[1:0] == 2'd3) begin
          finish_header();
        end else begin
          cnt_q = cnt_q + 3'd1;
        end
      end
      PhData: begin
        d      = masked_q ? (b ^ key_q[done_q[1:0]]) : b;
        done_q = done_q + 64'd1;
        eof    = (done_q >= len_q);
        if (eof) begin
          phase  = PhHdr1;
          done_q = '0;
        end
        push_item(d, 1'b1, eof);
      end
      // first header byte: fin and opcode, rsv bits dropped
      default: begin
        fin_q = b[7];
        op_q  = b[3:0];
        phase = PhHdr2;
      end
    endcase
  endtask

  task automatic flag_mismatch(string fld, int unsigned exp_v, int unsigned act_v);
    $display("%0t: %s expected %0h actual %0h", $time, fld, exp_v, act_v);
    fail_cnt_o = fail_cnt_o + 1;
  endtask

  // predict on accepted bytes, then compare accepted items in order
  always @(posedge clk_i or negedge rst_ni) begin
    wsfd_pkg::res_t exp_r;
    if (!rst_ni) begin
      phase    = PhHdr1;
      op_q     = '0;
      fin_q    = 1'b0;
      masked_q = 1'b0;
      len_q    = '0;
      cnt_q    = '0;
      key_q    = '{default: '0};
      done_q   = '0;
      frame_items_q.delete();
      fail_cnt_o = 0;
      pending_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        deframe_byte(in_mon.rx_byte);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (frame_items_q.size() == 0) begin
          $display("%0t: item with no expectation, expected none actual data %0h eof %0b",
                   $time, res_mon.data_byte, res_mon.end_of_frame);
          fail_cnt_o = fail_cnt_o + 1;
        end else begin
          exp_r = frame_items_q.pop_front();
          if (exp_r.data_byte !== res_mon.data_byte)
            flag_mismatch("data_byte", exp_r.data_byte, res_mon.data_byte);
          if (exp_r.has_data !== res_mon.has_data)
            flag_mismatch("has_data", exp_r.has_data, res_mon.has_data);
          if (exp_r.frame_code !== res_mon.frame_code)
            flag_mismatch("frame_code", exp_r.frame_code, res_mon.frame_code);
          if (exp_r.final_flag !== res_mon.final_flag)
            flag_mismatch("final_flag", exp_r.final_flag, res_mon.final_flag);
          if (exp_r.end_of_frame !== res_mon.end_of_frame)
            flag_mismatch("end_of_frame", exp_r.end_of_frame, res_mon.end_of_frame);
          if (exp_r.action !== res_mon.action)
            flag_mismatch("action", exp_r.action, res_mon.action);
        end
      end
      pending_o <= frame_items_q.size();
    end
  end

endmodule

// ===== verif/tb_websocket_frame_deframer_top.sv =====
// testbench top for the websocket frame deframer: byte stream stimulus and verdict
// depends on wsfd_pkg, wsfd_if, websocket_frame_deframer_top and wsfd_checker
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_top;

  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned StreamBytes = 1100;

  // opcodes that dispatch as ignore
  localparam logic [3:0] OpCont     = 4'h0;
  localparam logic [3:0] OpReserved = 4'hF;

  typedef enum int {LenShort, LenExt16, LenExt64} len_kind_e;
  typedef enum int {StallNone, StallLight, StallPeriodic, StallHeavy} stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  wsfd_in_if  in_ch ();
  wsfd_out_if res_ch ();

  int unsigned fail_cnt;
  int unsigned pending;

  logic [7:0] wire_bytes [$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  websocket_frame_deframer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch)
  );

  wsfd_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .res_mon    (res_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // add one byte to the end of the stream
  task automatic add_byte(input logic [7:0] v);
    wire_bytes.insert(wire_bytes.size(), v);
  endtask

  // append one frame; sent may be short of len for a frame left open at the end
  task automatic add_frame(input logic [3:0] op, input logic fin, input logic masked,
                           input len_kind_e kind, input logic [63:0] len, input int sent);
    logic [2:0] rsv;
    logic [7:0] b;
    rsv = 3'($urandom);
    add_byte({fin, rsv, op});
    case (kind)
      LenShort: add_byte({masked, len[6:0]});
      LenExt16: begin
        add_byte({masked, wsfd_pkg::Len7Ext16});
        add_byte(len[15:8]);
        add_byte(len[7:0]);
      end
      default: begin
        add_byte({masked, wsfd_pkg::Len7Ext64});
        for (int i = 7; i >= 0; i--) add_byte(len[i*8 +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 0; i < 4; i++) begin
        b = 8'($urandom);
        add_byte(b);
      end
    end
    for (int i = 0; i < sent; i++) begin
      b = 8'($urandom);
      add_byte(b);
    end
  endtask

  // receiver back-pressure, switching between patterns
  stall_mode_e stall_mode = StallNone;
  int unsigned stall_left = 0;
  int unsigned cyc = 0;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:     res_ch.ready <= 1'b1;
      StallLight:    res_ch.ready <= ($urandom_range(0, 3) != 0);
      StallPeriodic: res_ch.ready <= (cyc[2:0] < 3'd5);
      default:       res_ch.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // no progress on either channel for too long ends the run
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [3:0]  common_ops [6];
    logic [3:0]  op;
    logic        masked;
    logic [63:0] len;
    len_kind_e   kind;
    int unsigned pick;
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;

    common_ops = '{wsfd_pkg::OpText, wsfd_pkg::OpBinary, wsfd_pkg::OpClose,
                   wsfd_pkg::OpPing, wsfd_pkg::OpPong, OpCont};
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    rst_ni        = 1'b0;

    // directed frames: empty, masked empty, short extended lengths, every dispatch
    add_frame(wsfd_pkg::OpText, 1'b1, 1'b0, LenShort, 64'd0, 0);
    add_frame(wsfd_pkg::OpClose, 1'b1, 1'b1, LenShort, 64'd0, 0);
    add_frame(wsfd_pkg::OpPing, 1'b0, 1'b1, LenExt16, 64'd1, 1);
    add_frame(wsfd_pkg::OpBinary, 1'b1, 1'b0, LenExt64, 64'd0, 0);
    add_frame(wsfd_pkg::OpPong, 1'b1, 1'b0, LenShort, 64'd1, 1);
    add_frame(OpReserved, 1'b0, 1'b0, LenShort, 64'd0, 0);

    // random well-formed frames, mostly short
    while (wire_bytes.size() < StreamBytes) begin
      op     = $urandom_range(0, 1) ? 4'($urandom_range(0, 15))
                                    : common_ops[$urandom_range(0, 5)];
      masked = 1'($urandom_range(0, 1));
      pick   = $urandom_range(0, 99);
      if (pick < 60) begin
        kind = LenShort;
        len  = 64'($urandom_range(0, 12));
      end else if (pick < 70) begin
        kind = LenShort;
        len  = 64'($urandom_range(13, 125));
      end else if (pick < 85) begin
        kind = LenExt16;
        len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(126, 300))
                                           : 64'($urandom_range(0, 20));
      end else begin
        kind = LenExt64;
        len  = 64'($urandom_range(0, 20));
      end
      add_frame(op, 1'($urandom_range(0, 1)), masked, kind, len, int'(len));
    end
    // huge 64-bit length left open: counting must not end the frame early
    add_frame(wsfd_pkg::OpBinary, 1'b0, 1'b1, LenExt64, '1, 24);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender: bursts of bytes with random gaps
    idx = 0;
    while (idx < wire_bytes.size()) begin
      burst = $urandom_range(1, 30);
      gap   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      while (burst > 0 && idx < wire_bytes.size()) begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= wire_bytes[idx];
        @(posedge clk_i);
        while (!in_ch.ready) @(posedge clk_i);
        idx++;
        burst--;
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b0;

    // drain outstanding items, then allow for the output register
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/wsfd_if.sv
rtl/wsfd_parser.sv
rtl/wsfd_out_stage.sv
rtl/websocket_frame_deframer_top.sv
verif/wsfd_checker.sv
verif/tb_websocket_frame_deframer_top.sv
